// File: hw/rtl/b64d_pkg.sv
// shared types, codes and the alphabet lookup of the base64 decoder
`timescale 1ns / 1ps

package b64d_pkg;

  localparam logic [7:0] PAD_CHAR = 8'd61;

  localparam logic [1:0] ST_DATA = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  typedef enum logic [1:0] {
    PAD_NONE = 2'd0,
    PAD_ONE  = 2'd1,
    PAD_FULL = 2'd2
  } pad_state_t;

  // classified character as it travels through the queue
  typedef struct packed {
    logic       is_end;
    logic       is_pad;
    logic       sextet_ok;
    logic [5:0] sextet;
  } class_item_t;

  // {ok, value}: ok low for any code outside the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'd0;
      if (c >= 8'd65 && c <= 8'd90) begin
        t = c - 8'd65;
        return {1'b1, t[5:0]};
      end
      if (c >= 8'd97 && c <= 8'd122) begin
        t = c - 8'd71;
        return {1'b1, t[5:0]};
      end
      if (c >= 8'd48 && c <= 8'd57) begin
        t = c + 8'd4;
        return {1'b1, t[5:0]};
      end
      if (c == 8'd43) return {1'b1, 6'd62};
      if (c == 8'd47) return {1'b1, 6'd63};
      return {1'b0, t[5:0]};
    end
  endfunction

endpackage

// File: hw/rtl/b64d_front.sv
// front end: character classification and a two-entry queue
`timescale 1ns / 1ps

module b64d_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_text_char,
  input  logic                 in_end_of_text,
  output logic                 q_valid,
  input  logic                 q_pop,
  output b64d_pkg::class_item_t q_item
);
  import b64d_pkg::*;

  class_item_t entry_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push;
  logic        pop;
  logic [6:0]  lookup;
  class_item_t item_in;

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = entry_r[rd_ptr_r];

  assign lookup = sextet_of(in_text_char);

  always_comb begin
    item_in.is_end    = in_end_of_text;
    item_in.is_pad    = (in_text_char == PAD_CHAR);
    item_in.sextet_ok = lookup[6];
    item_in.sextet    = lookup[5:0];
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

// File: hw/rtl/b64d_back.sv
// back end: quantum decoding, padding and error rules, result register
`timescale 1ns / 1ps

module b64d_back #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  b64d_pkg::class_item_t q_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_data_byte,
  output logic [1:0]            out_status,
  output logic [15:0]           out_byte_total
);
  import b64d_pkg::*;

  localparam int EXT_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [1:0]            pos_r, pos_nxt;
  logic [5:0]            held_r, held_nxt;
  pad_state_t            pad_r, pad_nxt;
  logic                  err_r, err_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [COUNT_BITS-1:0] count_inc;

  logic                  out_valid_r;
  logic [7:0]            byte_r;
  logic [1:0]            status_r;
  logic [15:0]           total_r;

  logic                  advance;
  logic                  emit;
  logic [7:0]            res_byte;
  logic [1:0]            res_status;
  logic [COUNT_BITS-1:0] res_count;
  logic [EXT_BITS-1:0]   res_ext;
  logic [15:0]           res_total;
  logic                  is_data;

  assign advance = !out_valid_r || !out_stall;
  assign q_pop   = q_valid && advance;

  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + COUNT_BITS'(1);

  // plain sextet decode only when nothing earlier claims the character
  assign is_data = !q_item.is_end && !err_r && (pad_r == PAD_NONE)
                   && !(q_item.is_pad && pos_r[1]) && q_item.sextet_ok;

  // next state
  always_comb begin
    pos_nxt   = pos_r;
    held_nxt  = held_r;
    pad_nxt   = pad_r;
    err_nxt   = err_r;
    count_nxt = count_r;
    if (q_item.is_end) begin
      pos_nxt   = 2'd0;
      held_nxt  = 6'd0;
      pad_nxt   = PAD_NONE;
      err_nxt   = 1'b0;
      count_nxt = '0;
    end else if (!err_r) begin
      priority if (pad_r == PAD_ONE) begin
        if (q_item.is_pad) pad_nxt = PAD_FULL;
        else               err_nxt = 1'b1;
      end else if (pad_r != PAD_NONE) begin
        err_nxt = 1'b1;
      end else if (q_item.is_pad && pos_r[1]) begin
        pad_nxt = (pos_r == 2'd2) ? PAD_ONE : PAD_FULL;
      end else if (!q_item.sextet_ok) begin
        err_nxt = 1'b1;
      end else begin
        held_nxt = q_item.sextet;
        pos_nxt  = pos_r + 2'd1;
        if (pos_r != 2'd0) count_nxt = count_inc;
      end
    end
  end

  // result of the item at the head of the queue
  always_comb begin
    emit       = 1'b0;
    res_byte   = 8'd0;
    res_status = ST_ERR;
    res_count  = count_r;
    if (q_item.is_end) begin
      emit = !err_r;
      if (pad_r == PAD_ONE || (pad_r == PAD_NONE && pos_r != 2'd0)) begin
        res_status = ST_ERR;
      end else begin
        res_status = ST_DONE;
      end
    end else if (!err_r) begin
      if (is_data) begin
        emit       = (pos_r != 2'd0);
        res_status = ST_DATA;
        res_count  = count_inc;
        unique case (pos_r)
          2'd1:    res_byte = {held_r, q_item.sextet[5:4]};
          2'd2:    res_byte = {held_r[3:0], q_item.sextet[5:2]};
          2'd3:    res_byte = {held_r[1:0], q_item.sextet};
          default: res_byte = 8'd0;
        endcase
      end else begin
        // pad accepted where allowed, everything else here is a fault
        emit = !((pad_r == PAD_ONE && q_item.is_pad)
                 || (pad_r == PAD_NONE && q_item.is_pad && pos_r[1]));
      end
    end
  end

  assign res_ext   = EXT_BITS'(res_count);
  assign res_total = (res_ext > EXT_BITS'(17'h0FFFF)) ? 16'hFFFF : res_ext[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 2'd0;
      held_r      <= 6'd0;
      pad_r       <= PAD_NONE;
      err_r       <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        pos_r   <= pos_nxt;
        held_r  <= held_nxt;
        pad_r   <= pad_nxt;
        err_r   <= err_nxt;
        count_r <= count_nxt;
      end
      if (advance) begin
        out_valid_r <= q_pop && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      byte_r   <= res_byte;
      status_r <= res_status;
      total_r  <= res_total;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_byte  = byte_r;
  assign out_status     = status_r;
  assign out_byte_total = total_r;

endmodule

// File: hw/rtl/base64_stream_decoder_unit.sv
// top level of the strict base64 stream decoder
`timescale 1ns / 1ps

// channel  | direction | transaction carries
// ---------+-----------+------------------------------------------------
// in_      | input     | text_char, end_of_text (one character or end)
// out_     | output    | data_byte, status, byte_total (zero or one each)
//
// one character per clock sustained unless out_stall holds the output; each
// transaction crosses the classification front end, a two-entry queue and the
// decoding back end; out_valid is registered: a character is first written
// into the queue and its result then into the result register
// rst_n is synchronous: queue emptied, quantum, padding, error and count cleared
// out_stall holds the result register; the queue takes up to two more
// characters before in_stall rises

module base64_stream_decoder_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_char,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_data_byte,
  output logic [1:0]  out_status,
  output logic [15:0] out_byte_total
);
  import b64d_pkg::*;

  // queue head between the two halves
  logic        q_valid;
  logic        q_pop;
  class_item_t q_item;

  // front: alphabet lookup and padding detection, then queued
  b64d_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_text_char   (in_text_char),
    .in_end_of_text (in_end_of_text),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_item         (q_item)
  );

  // back: quantum state, padding rules, error latch and saturating count
  b64d_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_item         (q_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_byte  (out_data_byte),
    .out_status     (out_status),
    .out_byte_total (out_byte_total)
  );

endmodule
